### design/pnsc_pkg.sv
// shared constants and types for the palette nearest scaler
// no dependencies

package pnsc_pkg;

  // destination texture is square, DEST_SIZE texels a side
  localparam int DEST_SIZE = 256;
  localparam int DEST_W    = 8;
  localparam int COL_STEP  = 2 * DEST_SIZE;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int COLOR_W    = 32;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int FIFO_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS = 1'd1;

  localparam logic [CFG_W-1:0] SRC_COLS_RST = 11'd256;
  localparam logic [CFG_W-1:0] SRC_ROWS_RST = 11'd256;

  // input mode codes
  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  typedef struct packed {
    logic empty;
    logic full;
    logic almost_full;
  } fifo_status_t;

endpackage

### design/pnsc_fifo.sv
// short colour queue between the palette front end and the texel back end
// depends on pnsc_pkg

module pnsc_fifo #(
  parameter int DEPTH = pnsc_pkg::FIFO_DEPTH,
  parameter int WIDTH = pnsc_pkg::COLOR_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [WIDTH-1:0]          push_data,
  input  logic                      pop,
  output logic [WIDTH-1:0]          pop_data,
  output pnsc_pkg::fifo_status_t    status
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  assign pop_data           = slots[rd_ptr];
  assign status.empty       = (count == '0);
  assign status.full        = (count == NW'(DEPTH));
  assign status.almost_full = (count >= NW'(DEPTH - 1));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

### design/pnsc_front.sv
// front end: accepts words, writes palette entries, looks up pixel colours
// depends on pnsc_pkg

module pnsc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [pnsc_pkg::PIX_W-1:0]          palette_index,
  input  logic [pnsc_pkg::COLOR_W-1:0]        palette_color,
  input  logic [pnsc_pkg::PIX_W-1:0]          pixel,
  input  pnsc_pkg::fifo_status_t              fifo_st,
  output logic                                push,
  output logic [pnsc_pkg::COLOR_W-1:0]        push_data
);

  localparam int PAL_DEPTH = 2 ** pnsc_pkg::PIX_W;

  logic [pnsc_pkg::COLOR_W-1:0] palette [PAL_DEPTH];
  logic [pnsc_pkg::COLOR_W-1:0] rd_data;
  logic                         look_valid;
  logic                         accept;

  // keep room for the lookup already in flight
  assign in_ready = !fifo_st.full && !(look_valid && fifo_st.almost_full);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && mode == pnsc_pkg::MODE_PALETTE) begin
      palette[palette_index] <= palette_color;
    end
    if (accept && mode == pnsc_pkg::MODE_PIXEL) begin
      rd_data <= palette[pixel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else begin
      look_valid <= accept && mode == pnsc_pkg::MODE_PIXEL;
    end
  end

  assign push      = look_valid;
  assign push_data = rd_data;

endmodule

### design/pnsc_back.sv
// back end: walks source position, emits the texels each pixel selects
// depends on pnsc_pkg

module pnsc_back #(
  parameter int MAX_COLS = pnsc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = pnsc_pkg::MAX_ROWS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      restart,
  input  logic [$clog2(MAX_COLS + 1)-1:0]           cols,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]           rows,
  input  pnsc_pkg::fifo_status_t                    fifo_st,
  input  logic [pnsc_pkg::COLOR_W-1:0]              job_data,
  output logic                                      pop,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [pnsc_pkg::DEST_W-1:0]               dest_row,
  output logic [pnsc_pkg::DEST_W-1:0]               dest_col,
  output logic [pnsc_pkg::COLOR_W-1:0]              texel,
  output logic                                      last
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ERW = $clog2(MAX_ROWS + 1);
  localparam int DCW = pnsc_pkg::DEST_W + 1;
  localparam int CAW = $clog2(MAX_COLS * (2 * pnsc_pkg::DEST_SIZE + 3) + 1);
  localparam int RAW = $clog2((pnsc_pkg::DEST_SIZE + 1) * MAX_ROWS + 1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  back_state_t                  state;
  logic [CW-1:0]                source_col;
  logic [RW-1:0]                source_row;
  logic [DCW-1:0]               next_dest_row;
  logic [RAW-1:0]               row_acc;
  logic [RAW-1:0]               row_limit;
  logic [DCW-1:0]               next_dest_col;
  logic [CAW-1:0]               col_acc;
  logic [CAW-1:0]               col_limit;
  logic [pnsc_pkg::COLOR_W-1:0] job_color;
  logic                         job_sel;

  logic           slot_free;
  logic           step_cond;
  logic           more;
  logic           advance;
  logic           emit;
  logic           finish;
  logic           sel_now;
  logic           row_end;
  logic           frame_end;
  logic [CAW-1:0] col_acc_next;
  logic [DCW-1:0] next_dest_col_next;

  assign slot_free = !out_valid || out_ready;

  // col_acc holds cols*(2j+1), col_limit holds (source_col+1)*2*DEST_SIZE
  assign col_acc_next       = col_acc + (CAW'(cols) << 1);
  assign next_dest_col_next = next_dest_col + DCW'(1);
  assign step_cond = (next_dest_col < DCW'(pnsc_pkg::DEST_SIZE)) && (col_acc < col_limit);
  assign more = (next_dest_col_next < DCW'(pnsc_pkg::DEST_SIZE))
                && (col_acc_next < col_limit);

  assign advance = (state == ST_RUN) && step_cond && (!job_sel || slot_free);
  assign emit    = advance && job_sel;
  assign finish  = (state == ST_RUN) && (!step_cond || (advance && !more));
  assign pop     = (state == ST_LOAD) && !fifo_st.empty;

  // row selection only thins rows when the frame is taller than the texture
  assign sel_now = (next_dest_row < DCW'(pnsc_pkg::DEST_SIZE))
                   && ((int'(rows) <= pnsc_pkg::DEST_SIZE) || (row_acc < row_limit));

  assign row_end   = (ECW'(source_col) + ECW'(1)) >= cols;
  assign frame_end = (ERW'(source_row) + ERW'(1)) >= rows;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state         <= ST_LOAD;
      source_col    <= '0;
      source_row    <= '0;
      next_dest_row <= '0;
      row_acc       <= '0;
      row_limit     <= RAW'(pnsc_pkg::DEST_SIZE);
      next_dest_col <= '0;
      col_acc       <= CAW'(cols);
      col_limit     <= CAW'(pnsc_pkg::COL_STEP);
    end else begin
      case (state)
        ST_LOAD: begin
          if (pop) begin
            job_color <= job_data;
            job_sel   <= sel_now;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance && !(finish && row_end)) begin
            next_dest_col <= next_dest_col_next;
            col_acc       <= col_acc_next;
          end
          if (finish) begin
            state <= ST_LOAD;
            if (row_end) begin
              source_col    <= '0;
              next_dest_col <= '0;
              col_acc       <= CAW'(cols);
              col_limit     <= CAW'(pnsc_pkg::COL_STEP);
              if (frame_end) begin
                source_row    <= '0;
                next_dest_row <= '0;
                row_acc       <= '0;
                row_limit     <= RAW'(pnsc_pkg::DEST_SIZE);
              end else begin
                source_row <= source_row + RW'(1);
                row_limit  <= row_limit + RAW'(pnsc_pkg::DEST_SIZE);
                if (job_sel) begin
                  next_dest_row <= next_dest_row + DCW'(1);
                  row_acc       <= row_acc + RAW'(rows);
                end
              end
            end else begin
              source_col <= source_col + CW'(1);
              col_limit  <= col_limit + CAW'(pnsc_pkg::COL_STEP);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dest_row <= next_dest_row[pnsc_pkg::DEST_W-1:0];
      dest_col <= next_dest_col[pnsc_pkg::DEST_W-1:0];
      texel    <= job_color;
      last     <= !more;
    end
  end

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    next_dest_col <= DCW'(pnsc_pkg::DEST_SIZE))
    else $error("destination column ran past the texture");

  a_emit_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RUN && $past(job_sel))
    else $error("texel emitted outside a selected pixel");
`endif

endmodule

### design/palette_nearest_scaler.sv
// palette nearest scaler: a looked-up pixel colour is registered, queued, loaded by the
// back end; its texels go out through the output register. a pixel holds the back end
// over the n destination columns it covers (up to 64; one texel per cycle on selected
// rows while out_ready allows); the back end's column walk sets the rate, and it takes
// no new pixel until the walk ends. reset clears control state and restores 256 x 256;
// palette contents stay undefined until written. a register write restarts the frame.

module palette_nearest_scaler #(
  parameter int MAX_COLS = pnsc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = pnsc_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pnsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pnsc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic [pnsc_pkg::PIX_W-1:0]           palette_index,
  input  logic [pnsc_pkg::COLOR_W-1:0]         palette_color,
  input  logic [pnsc_pkg::PIX_W-1:0]           pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pnsc_pkg::DEST_W-1:0]          dest_row,
  output logic [pnsc_pkg::DEST_W-1:0]          dest_col,
  output logic [pnsc_pkg::COLOR_W-1:0]         texel,
  output logic                                 last
);

  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int ERW = $clog2(MAX_ROWS + 1);

  logic [pnsc_pkg::CFG_W-1:0]   src_cols;
  logic [pnsc_pkg::CFG_W-1:0]   src_rows;
  logic                         restart;
  logic [ECW-1:0]               cols;
  logic [ERW-1:0]               rows;
  pnsc_pkg::fifo_status_t       fifo_st;
  logic                         push;
  logic [pnsc_pkg::COLOR_W-1:0] push_data;
  logic                         pop;
  logic [pnsc_pkg::COLOR_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols <= pnsc_pkg::SRC_COLS_RST;
      src_rows <= pnsc_pkg::SRC_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pnsc_pkg::REG_SRC_COLS: src_cols <= cfg_data;
        pnsc_pkg::REG_SRC_ROWS: src_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // back end restarts in the cycle after the write, once the new sizes are in place
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else begin
      restart <= cfg_we;
    end
  end

  // saturate sizes to the supported range
  always_comb begin
    if (src_cols < pnsc_pkg::CFG_W'(4)) begin
      cols = ECW'(4);
    end else if (int'(src_cols) > MAX_COLS) begin
      cols = ECW'(MAX_COLS);
    end else begin
      cols = ECW'(src_cols);
    end
    if (src_rows < pnsc_pkg::CFG_W'(1)) begin
      rows = ERW'(1);
    end else if (int'(src_rows) > MAX_ROWS) begin
      rows = ERW'(MAX_ROWS);
    end else begin
      rows = ERW'(src_rows);
    end
  end

  pnsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .pixel         (pixel),
    .fifo_st       (fifo_st),
    .push          (push),
    .push_data     (push_data)
  );

  pnsc_fifo #(
    .DEPTH (pnsc_pkg::FIFO_DEPTH),
    .WIDTH (pnsc_pkg::COLOR_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (fifo_st)
  );

  pnsc_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .cols      (cols),
    .rows      (rows),
    .fifo_st   (fifo_st),
    .job_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dest_row  (dest_row),
    .dest_col  (dest_col),
    .texel     (texel),
    .last      (last)
  );

endmodule
